[src/ophp_pkg.sv]
package ophp_pkg;

  localparam int unsigned CORDIC_STEPS = 28;
  localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         ch;
    logic signed [23:0] smp;
    logic [21:0]        f;
  } q_item_t;

  typedef struct packed {
    logic    vld;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic [21:0]        cutoff;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] b1;
    logic signed [23:0] x1;
    logic signed [30:0] y1;
  } ch_rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIV1, S_THETA, S_CORDIC, S_PREP, S_DIV2,
    S_MUL0, S_MUL1, S_MUL2, S_ROUND, S_DONE
  } eng_state_t;

  typedef struct packed {
    logic pop;
    logic clr_hist;
    logic mem_we;
    logic out_load;
  } eng_ctl_t;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[src/ophp_front.sv]
module ophp_front #(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [55:0]       in_tdata,
  input  logic              in_tuser,
  output ophp_pkg::q_head_t q_head,
  input  logic              q_pop
);

  ophp_pkg::q_item_t fifo_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       xfer, keep, push;
  ophp_pkg::q_item_t item;

  assign in_tready = (cnt_r != 2'd2);
  assign xfer = in_tvalid && in_tready;

  always_comb begin
    item.cmd = in_tuser;
    item.ch  = in_tdata[2:0];
    item.smp = $signed(in_tdata[26:3]);
    item.f   = in_tdata[49] ? 22'd0 : in_tdata[48:27];
  end

  assign keep = (item.cmd == ophp_pkg::CMD_CLEAR) || (32'(item.ch) < CHANNELS);
  assign push = xfer && keep;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= item;
  end

  assign q_head.vld  = (cnt_r != 2'd0);
  assign q_head.item = fifo_r[rp_r];

endmodule

[src/ophp_back.sv]
module ophp_back #(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [17:0]       cfg_data,
  input  ophp_pkg::q_head_t q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ophp_pkg::eng_state_t state_r, state_nxt;
  ophp_pkg::eng_ctl_t   ctl;

  ophp_pkg::ch_rec_t mem [CHANNELS];
  ophp_pkg::ch_rec_t rd_r, wrec;
  logic [CHANNELS-1:0] coef_vld_r, hist_vld_r;

  logic [17:0]        rate_r;
  logic [20:0]        nyq;
  ophp_pkg::q_item_t  item_r;
  logic [CH_W-1:0]    ra, wa;
  logic [4:0]         cnt_r;
  logic [21:0]        rem1_r;
  logic [22:0]        rs1;
  logic [31:0]        p_r;
  logic [63:0]        prod;
  logic signed [32:0] cx_r, cy_r, cz_r, dx, dy, at;
  logic [31:0]        c_v, s_v;
  logic [32:0]        sum_v, sum_r;
  logic [62:0]        n_v;
  logic [32:0]        rem2_r;
  logic [33:0]        rs2;
  logic               q_bit;
  logic [30:0]        nlo_r, q2_r, q2_nxt;
  logic signed [31:0] a0_r, a1_r, b1_r, a0_q;
  logic signed [23:0] x1_r;
  logic signed [30:0] y1_r, y_r;
  logic signed [55:0] p0, p1;
  logic signed [62:0] p2;
  logic signed [63:0] acc_r, rnd, t;
  logic               hit, out_free;
  logic               out_vld_r;
  logic [2:0]         out_ch_r;
  logic [24:0]        out_smp_r;

  assign nyq      = {rate_r, 3'b000};
  assign ra       = CH_W'(q_head.item.ch);
  assign wa       = CH_W'(item_r.ch);
  assign out_free = !out_vld_r || out_tready;
  assign hit      = coef_vld_r[wa] && (rd_r.cutoff == item_r.f);

  assign rs1 = {rem1_r, 1'b0};
  assign prod = p_r * ophp_pkg::HALF_PI_Q30;
  assign dx = cy_r >>> cnt_r;
  assign dy = cx_r >>> cnt_r;
  assign at = $signed({1'b0, ophp_pkg::atan_q30(cnt_r)});
  assign c_v = cx_r[32] ? 32'd0 : cx_r[31:0];
  assign s_v = cy_r[32] ? 32'd0 : cy_r[31:0];
  assign sum_v = {1'b0, c_v} + {1'b0, s_v};
  assign n_v = (63'(c_v) << 30) + 63'(sum_v >> 1);
  assign rs2 = {rem2_r, nlo_r[30]};
  assign q_bit = (rs2 >= {1'b0, sum_r});
  assign q2_nxt = {q2_r[29:0], q_bit};
  assign a0_q = $signed({1'b0, q2_nxt});
  assign p0 = a0_r * item_r.smp;
  assign p1 = a1_r * x1_r;
  assign p2 = b1_r * y1_r;
  assign rnd = acc_r + 64'sd536870912;
  assign t = rnd >>> 30;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ophp_pkg::S_IDLE:
        if (q_head.vld && q_head.item.cmd == ophp_pkg::CMD_FILTER) begin
          state_nxt = ophp_pkg::S_READ;
        end
      ophp_pkg::S_READ: begin
        if (hit || item_r.f == 22'd0 || item_r.f >= 22'(nyq)) begin
          state_nxt = ophp_pkg::S_MUL0;
        end else begin
          state_nxt = ophp_pkg::S_DIV1;
        end
      end
      ophp_pkg::S_DIV1:
        if (cnt_r == 5'd31) state_nxt = ophp_pkg::S_THETA;
      ophp_pkg::S_THETA: state_nxt = ophp_pkg::S_CORDIC;
      ophp_pkg::S_CORDIC:
        if (cnt_r == 5'(ophp_pkg::CORDIC_STEPS - 1)) state_nxt = ophp_pkg::S_PREP;
      ophp_pkg::S_PREP:
        state_nxt = (sum_v == 33'd0) ? ophp_pkg::S_MUL0 : ophp_pkg::S_DIV2;
      ophp_pkg::S_DIV2:
        if (cnt_r == 5'd30) state_nxt = ophp_pkg::S_MUL0;
      ophp_pkg::S_MUL0:  state_nxt = ophp_pkg::S_MUL1;
      ophp_pkg::S_MUL1:  state_nxt = ophp_pkg::S_MUL2;
      ophp_pkg::S_MUL2:  state_nxt = ophp_pkg::S_ROUND;
      ophp_pkg::S_ROUND: state_nxt = ophp_pkg::S_DONE;
      ophp_pkg::S_DONE:
        if (out_free) state_nxt = ophp_pkg::S_IDLE;
      default: state_nxt = ophp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ophp_pkg::S_IDLE: begin
        ctl.pop      = q_head.vld;
        ctl.clr_hist = q_head.vld && q_head.item.cmd == ophp_pkg::CMD_CLEAR;
      end
      ophp_pkg::S_DONE: begin
        ctl.mem_we   = out_free;
        ctl.out_load = out_free;
      end
      default: ;
    endcase
  end

  assign q_pop = ctl.pop;

  always_comb begin
    wrec.cutoff = item_r.f;
    wrec.a0     = a0_r;
    wrec.a1     = a1_r;
    wrec.b1     = b1_r;
    wrec.x1     = item_r.smp;
    wrec.y1     = y_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_we) mem[wa] <= wrec;
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ophp_pkg::S_IDLE;
      rate_r     <= 18'd48000;
      coef_vld_r <= '0;
      hist_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        rate_r     <= cfg_data;
        coef_vld_r <= '0;
      end
      if (ctl.clr_hist) hist_vld_r <= '0;
      if (ctl.mem_we) begin
        coef_vld_r[wa] <= 1'b1;
        hist_vld_r[wa] <= 1'b1;
      end
      if (ctl.out_load) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ophp_pkg::S_IDLE: begin
        item_r <= q_head.item;
        cnt_r  <= 5'd0;
      end
      ophp_pkg::S_READ: begin
        x1_r   <= hist_vld_r[wa] ? rd_r.x1 : 24'sd0;
        y1_r   <= hist_vld_r[wa] ? rd_r.y1 : 31'sd0;
        rem1_r <= item_r.f;
        cnt_r  <= 5'd0;
        if (hit) begin
          a0_r <= rd_r.a0;
          a1_r <= rd_r.a1;
          b1_r <= rd_r.b1;
        end else if (item_r.f == 22'd0) begin
          a0_r <= '0;
          a1_r <= '0;
          b1_r <= '0;
        end else begin
          a0_r <= $signed(ophp_pkg::ONE_Q30);
          a1_r <= '0;
          b1_r <= '0;
        end
      end
      ophp_pkg::S_DIV1: begin
        cnt_r <= cnt_r + 5'd1;
        if (rs1 >= 23'(nyq)) begin
          rem1_r <= 22'(rs1 - 23'(nyq));
          p_r    <= {p_r[30:0], 1'b1};
        end else begin
          rem1_r <= rs1[21:0];
          p_r    <= {p_r[30:0], 1'b0};
        end
      end
      ophp_pkg::S_THETA: begin
        cz_r  <= $signed({1'b0, prod[63:32]});
        cx_r  <= $signed({1'b0, ophp_pkg::ONE_Q30});
        cy_r  <= '0;
        cnt_r <= 5'd0;
      end
      ophp_pkg::S_CORDIC: begin
        cnt_r <= cnt_r + 5'd1;
        if (!cz_r[32]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end
      end
      ophp_pkg::S_PREP: begin
        sum_r  <= sum_v;
        rem2_r <= {1'b0, n_v[62:31]};
        nlo_r  <= n_v[30:0];
        q2_r   <= '0;
        cnt_r  <= 5'd0;
        if (sum_v == 33'd0) begin
          a0_r <= $signed(ophp_pkg::ONE_Q30);
          a1_r <= -$signed(ophp_pkg::ONE_Q30);
          b1_r <= $signed(ophp_pkg::ONE_Q30);
        end
      end
      ophp_pkg::S_DIV2: begin
        cnt_r <= cnt_r + 5'd1;
        nlo_r <= {nlo_r[29:0], 1'b0};
        q2_r  <= q2_nxt;
        if (q_bit) begin
          rem2_r <= 33'(rs2 - {1'b0, sum_r});
        end else begin
          rem2_r <= rs2[32:0];
        end
        if (cnt_r == 5'd30) begin
          a0_r <= a0_q;
          a1_r <= -a0_q;
          b1_r <= (a0_q <<< 1) - $signed(ophp_pkg::ONE_Q30);
        end
      end
      ophp_pkg::S_MUL0:  acc_r <= 64'(p0);
      ophp_pkg::S_MUL1:  acc_r <= acc_r + 64'(p1);
      ophp_pkg::S_MUL2:  acc_r <= (acc_r <<< 6) + 64'(p2);
      ophp_pkg::S_ROUND: begin
        if (t > 64'sd1073741823) y_r <= 31'sh3FFFFFFF;
        else if (t < -64'sd1073741824) y_r <= 31'sh40000000;
        else y_r <= 31'(t);
      end
      ophp_pkg::S_DONE: begin
        if (ctl.out_load) begin
          out_ch_r  <= item_r.ch;
          out_smp_r <= y_r[30:6];
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_smp_r, out_ch_r};

endmodule

[src/one_pole_highpass_variable_cutoff.sv]
// Channel | Dir | Ports                           | Contents
// in      | in  | in_tvalid/in_tready/in_tdata    | tdata: channel, sample_in, cutoff
//         |     | in_tuser                        | command
// out     | out | out_tvalid/out_tready/out_tdata | tdata: channel_out, sample_out
// cfg     | in  | cfg_we/cfg_data                 | sample_rate_hz
// A filter item on a channel whose cutoff is unchanged passes the engine states READ, MUL0, MUL1, MUL2, ROUND and DONE.
// A change to a nonzero cutoff below the Nyquist limit adds a divider for the normalized
// frequency, a 28-step CORDIC and a divider for a0, all on one unit.
// A clear item is taken from the queue in the idle state and gives no transfer on the output.
// Reset is synchronous and active low; it sets the rate to 48000 and drops all
// cached coefficients and history. A two-entry queue keeps input taking items
// while the engine is busy or the output register waits.
module one_pole_highpass_variable_cutoff #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // channel[2:0], sample_in[26:3], cutoff[49:27]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // channel_out[2:0], sample_out[27:3]
  input  logic        cfg_we,
  input  logic [17:0] cfg_data
);

  ophp_pkg::q_head_t q_head;
  logic              q_pop;

  ophp_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  ophp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  a_out_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[2:0]) < CHANNELS))
    else $error("result channel out of range");

  a_pop_vld: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.vld)
    else $error("queue popped while empty");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 8;
  localparam longint ONE = 64'sd1073741824;
  localparam longint YMAX = 64'sd1073741823;
  localparam longint YMIN = -64'sd1073741824;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic [2:0]         ch;
    logic signed [24:0] smp;
  } hp_result_t;

  class hp_scoreboard;
    hp_result_t pending[$];
    int errors;
    int seen;
    logic [17:0] rate;
    bit          cvalid[NCH];
    logic [21:0] cut[NCH];
    longint      a0[NCH], a1[NCH], b1[NCH], x1[NCH], y1[NCH];

    function void reset_state();
      rate = 18'd48000;
      for (int i = 0; i < NCH; i++) begin
        cvalid[i] = 0; cut[i] = 0; a0[i] = 0; a1[i] = 0; b1[i] = 0;
        x1[i] = 0; y1[i] = 0;
      end
    endfunction

    function void set_rate(logic [17:0] r);
      rate = r;
      for (int i = 0; i < NCH; i++) cvalid[i] = 0;
    endfunction

    function void update_gains(int ch, logic [21:0] f);
      longint unsigned nyq, p, c, s, sum;
      longint z, x, y, dx, dy, g;
      nyq = longint'(rate) * 8;
      cut[ch] = f;
      cvalid[ch] = 1;
      if (f == 0) begin
        a0[ch] = 0; a1[ch] = 0; b1[ch] = 0;
      end else if (longint'(f) >= nyq) begin
        a0[ch] = ONE; a1[ch] = 0; b1[ch] = 0;
      end else begin
        p = (longint'(f) << 32) / nyq;
        z = longint'((p * 64'h6487ED51) >> 32);
        x = ONE; y = 0;
        for (int i = 0; i < ophp_pkg::CORDIC_STEPS; i++) begin
          dx = y >>> i; dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ophp_pkg::atan_q30(5'(i)));
          end else begin
            x += dx; y -= dy; z += longint'(ophp_pkg::atan_q30(5'(i)));
          end
        end
        c = x > 0 ? x : 0;
        s = y > 0 ? y : 0;
        sum = c + s;
        g = (sum == 0) ? ONE : longint'((c * ONE + sum / 2) / sum);
        a0[ch] = g; a1[ch] = -g; b1[ch] = 2 * g - ONE;
      end
    endfunction

    function void note_input(logic cmd, logic [2:0] ch, logic signed [23:0] x,
                             logic signed [22:0] fin);
      longint acc, y;
      logic [21:0] f;
      hp_result_t r;
      if (cmd == ophp_pkg::CMD_CLEAR) begin
        for (int i = 0; i < NCH; i++) begin
          x1[i] = 0; y1[i] = 0;
        end
        return;
      end
      f = fin < 0 ? 22'd0 : fin[21:0];
      if (!cvalid[ch] || f != cut[ch]) update_gains(ch, f);
      acc = (a0[ch] * longint'(x) + a1[ch] * x1[ch]) * 64 + b1[ch] * y1[ch];
      y = (acc + (64'sd1 << 29)) >>> 30;
      if (y > YMAX) y = YMAX;
      if (y < YMIN) y = YMIN;
      x1[ch] = x;
      y1[ch] = y;
      r.ch = ch;
      r.smp = 25'(y >>> 6);
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] d);
      hp_result_t e;
      seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, d);
        return;
      end
      e = pending.pop_front();
      if (d[2:0] !== e.ch) begin
        errors++;
        $display("%0t: channel_out expected %0d actual %0d", $time, e.ch, d[2:0]);
      end
      if ($signed(d[27:3]) !== e.smp) begin
        errors++;
        $display("%0t: sample_out expected %0d actual %0d", $time, e.smp,
                 $signed(d[27:3]));
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0, cfg_we = 0;
  logic [55:0] in_tdata = '0;
  logic [17:0] cfg_data = '0;
  logic in_tready, out_tvalid;
  logic [31:0] out_tdata;

  hp_scoreboard sb = new();
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  longint cycles = 0;
  int sent = 0;

  always #4 clk = ~clk;

  one_pole_highpass_variable_cutoff #(.CHANNELS(NCH)) dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** one_pole_highpass_variable_cutoff: FAILED **");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_input(in_tuser, in_tdata[2:0], in_tdata[26:3], in_tdata[49:27]);
      sent++;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk)
    out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);

  task automatic send_item(logic cmd, logic [2:0] ch, logic [23:0] x, logic [22:0] f);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {6'd0, f, x, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_rate(logic [17:0] r);
    drain();
    cfg_we <= 1;
    cfg_data <= r;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_rate(r);
  endtask

  function automatic logic [22:0] pick_cutoff(int ch, logic [17:0] r);
    int k = $urandom_range(99);
    if (k < 55) return 23'(sb.cut[ch]);
    if (k < 60) return 23'(-$urandom_range(3145728, 1));
    if (k < 63) return 23'd0;
    if (k < 68) return 23'(r * 8 + $urandom_range(3));
    if (k < 71) return 23'($urandom_range(3145727));
    if (k < 75) return 23'(r * 8 - 1);
    return 23'($urandom_range(r * 8 - 1, 1));
  endfunction

  task automatic random_phase(int n, logic [17:0] r);
    int ch;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(7);
      if ($urandom_range(99) < 2)
        send_item(ophp_pkg::CMD_CLEAR, 3'(ch), 24'($urandom), 23'($urandom));
      else
        send_item(ophp_pkg::CMD_FILTER, 3'(ch), 24'($urandom), pick_cutoff(ch, r));
    end
  endtask

  initial begin
    logic [17:0] rates[5] = '{18'd8000, 18'd192000, 18'd44100, 18'd262143, 18'd0};
    sb.reset_state();
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_item(ophp_pkg::CMD_FILTER, 0, 24'h7FFFFF, 23'd8000);
    send_item(ophp_pkg::CMD_FILTER, 0, 24'h800000, 23'd8000);
    send_item(ophp_pkg::CMD_FILTER, 0, 24'h7FFFFF, 23'd8000);
    send_item(ophp_pkg::CMD_FILTER, 1, 24'h800000, 23'h400000);
    send_item(ophp_pkg::CMD_FILTER, 2, 24'h123456, 23'd0);
    send_item(ophp_pkg::CMD_FILTER, 3, 24'h7FFFFF, 23'd384000);
    send_item(ophp_pkg::CMD_FILTER, 3, 24'h800000, 23'h3FFFFF);
    send_item(ophp_pkg::CMD_FILTER, 4, 24'h7FFFFF, 23'd383999);
    send_item(ophp_pkg::CMD_FILTER, 4, 24'h800000, 23'd383999);
    send_item(ophp_pkg::CMD_FILTER, 5, 24'h7FFFFF, 23'd1);
    send_item(ophp_pkg::CMD_FILTER, 5, 24'h000000, 23'd1);
    send_item(ophp_pkg::CMD_FILTER, 6, 24'h555555, 23'd192000);
    send_item(ophp_pkg::CMD_FILTER, 7, 24'hAAAAAA, 23'd96000);
    send_item(ophp_pkg::CMD_CLEAR, 7, 24'hFFFFFF, 23'h7FFFFF);
    send_item(ophp_pkg::CMD_FILTER, 0, 24'h7FFFFF, 23'd8000);
    send_item(ophp_pkg::CMD_FILTER, 7, 24'h000001, 23'd96000);
    drain();
    hold_recv = 1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_recv = 0;
      end
      random_phase(12, sb.rate);
    join
    drain();
    send_idle = 15; recv_idle = 64;
    random_phase(300, sb.rate);
    for (int p = 0; p < 5; p++) begin
      write_rate(rates[p]);
      if (p == 2) begin
        send_idle = 64; recv_idle = 15;
      end
      if (p == 4) begin
        send_idle = 0; recv_idle = 0;
      end
      random_phase(p == 4 ? 60 : 200, rates[p] == 0 ? 18'd1 : rates[p]);
    end
    write_rate(18'd48000);
    random_phase(150, 18'd48000);
    drain();
    $display("Sent %0d items over six sample rates incl. 0 and max; checked %0d results.",
             sent, sb.seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** one_pole_highpass_variable_cutoff: PASSED **");
    else
      $display("** one_pole_highpass_variable_cutoff: FAILED **");
    $finish;
  end
endmodule

[sim.f]
src/ophp_pkg.sv
src/ophp_front.sv
src/ophp_back.sv
src/one_pole_highpass_variable_cutoff.sv
tb/testbench.sv
